@@ rtl/core/hsl_pkg.sv @@
// shared types, constants and codes for the http status line parser
package hsl_pkg;

  // length limits of the status line
  localparam int unsigned VERSION_LEN = 8;
  localparam int unsigned REASON_MAX  = 256;

  // counter widths that hold each limit itself
  localparam int unsigned VER_CNT_W = $clog2(VERSION_LEN + 1);
  localparam int unsigned RSN_CNT_W = $clog2(REASON_MAX + 1);

  // depth of the queue between front and back
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  // character codes
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // status saturation limit
  localparam logic [15:0] STATUS_MAX = 16'hffff;

  // byte kind codes on the result channel
  localparam logic [2:0] KIND_SKIP    = 3'd0;
  localparam logic [2:0] KIND_VERSION = 3'd1;
  localparam logic [2:0] KIND_REASON  = 3'd2;
  localparam logic [2:0] KIND_HEADER  = 3'd3;
  localparam logic [2:0] KIND_ERROR   = 3'd4;

  // one classified input byte
  typedef struct packed {
    logic [7:0] byte_val;
    logic       is_blank;
    logic       is_eol;
    logic       is_digit;
    logic [3:0] digit;
  } hsl_item_t;

endpackage

@@ rtl/core/hsl_front.sv @@
// front part: accepts input bytes and classifies them
module hsl_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  output logic              push_valid,
  input  logic              push_ready,
  output hsl_pkg::hsl_item_t push_item
);
  import hsl_pkg::*;

  logic      vld_r;
  hsl_item_t item_r;
  hsl_item_t item_nxt;
  logic      take;

  // classify the incoming byte
  always_comb begin
    item_nxt.byte_val = in_byte;
    item_nxt.is_blank = (in_byte == CH_SPACE) || (in_byte == CH_TAB);
    item_nxt.is_eol   = (in_byte == CH_CR) || (in_byte == CH_LF);
    item_nxt.is_digit = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
    item_nxt.digit    = 4'(in_byte - CH_ZERO);
  end

  // one holding register, refilled as soon as it drains
  assign in_ready   = !vld_r || push_ready;
  assign take       = in_valid && in_ready;
  assign push_valid = vld_r;
  assign push_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (take) begin
      vld_r <= 1'b1;
    end else if (push_ready) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= item_nxt;
    end
  end

endmodule

@@ rtl/core/hsl_queue.sv @@
// short queue of classified bytes between front and back
module hsl_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  output logic               push_ready,
  input  hsl_pkg::hsl_item_t push_item,
  output logic               pop_valid,
  input  logic               pop_ready,
  output hsl_pkg::hsl_item_t pop_item
);
  import hsl_pkg::*;

  hsl_item_t            slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r;
  logic [Q_PTR_W-1:0]   rd_ptr_r;
  logic [Q_CNT_W-1:0]   cnt_r;
  logic                 do_push;
  logic                 do_pop;

  assign push_ready = (cnt_r != Q_CNT_W'(Q_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_item   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointer and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

@@ rtl/core/hsl_back.sv @@
// back part: status line state machine and result register
module hsl_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  hsl_pkg::hsl_item_t pop_item,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_byte_kind,
  output logic [7:0]         out_byte,
  output logic [15:0]        out_status_code,
  output logic               out_line_done
);
  import hsl_pkg::*;

  typedef enum logic [2:0] {
    PH_VERSION,
    PH_STATUS,
    PH_REASON,
    PH_HEADER,
    PH_ERROR
  } phase_t;

  phase_t               phase_r, phase_nxt;
  logic [VER_CNT_W-1:0] ver_cnt_r, ver_cnt_nxt;
  logic [RSN_CNT_W-1:0] rsn_cnt_r, rsn_cnt_nxt;
  logic [15:0]          accum_r, accum_nxt;
  logic                 out_vld_r;
  logic [2:0]           kind_r, kind_nxt;
  logic [7:0]           byte_r;
  logic                 done_r, done_nxt;
  logic [19:0]          accum_ext;
  logic                 fire;

  // next item moves when the result register is free or draining
  assign fire      = pop_valid && (!out_vld_r || out_ready);
  assign pop_ready = !out_vld_r || out_ready;

  // status times ten plus digit, saturated
  assign accum_ext = ({4'b0, accum_r} * 20'd10) + {16'b0, pop_item.digit};

  // per-byte phase decisions
  always_comb begin
    phase_nxt   = phase_r;
    ver_cnt_nxt = ver_cnt_r;
    rsn_cnt_nxt = rsn_cnt_r;
    accum_nxt   = accum_r;
    kind_nxt    = KIND_ERROR;
    done_nxt    = 1'b0;
    case (phase_r)
      PH_VERSION: begin
        if (pop_item.is_blank) begin
          if (ver_cnt_r == '0) begin
            kind_nxt = KIND_SKIP;
          end else if (ver_cnt_r != VER_CNT_W'(VERSION_LEN)) begin
            phase_nxt = PH_ERROR;
          end else begin
            accum_nxt = '0;
            phase_nxt = PH_STATUS;
            kind_nxt  = KIND_SKIP;
          end
        end else if (pop_item.is_eol || (ver_cnt_r >= VER_CNT_W'(VERSION_LEN))) begin
          phase_nxt = PH_ERROR;
        end else begin
          ver_cnt_nxt = ver_cnt_r + 1'b1;
          kind_nxt    = KIND_VERSION;
        end
      end
      PH_STATUS: begin
        if (pop_item.is_blank) begin
          if (accum_r != '0) begin
            phase_nxt = PH_REASON;
          end
          kind_nxt = KIND_SKIP;
        end else if (pop_item.is_eol) begin
          phase_nxt = PH_HEADER;
          kind_nxt  = KIND_HEADER;
          done_nxt  = 1'b1;
        end else if (pop_item.is_digit) begin
          accum_nxt = (accum_ext > {4'b0, STATUS_MAX}) ? STATUS_MAX : accum_ext[15:0];
          kind_nxt  = KIND_SKIP;
        end else begin
          phase_nxt = PH_ERROR;
        end
      end
      PH_REASON: begin
        if (pop_item.is_eol) begin
          phase_nxt = PH_HEADER;
          kind_nxt  = KIND_HEADER;
          done_nxt  = 1'b1;
        end else if (pop_item.is_blank && (rsn_cnt_r == '0)) begin
          kind_nxt = KIND_SKIP;
        end else if (rsn_cnt_r >= RSN_CNT_W'(REASON_MAX)) begin
          phase_nxt = PH_ERROR;
        end else begin
          rsn_cnt_nxt = rsn_cnt_r + 1'b1;
          kind_nxt    = KIND_REASON;
        end
      end
      PH_HEADER: begin
        kind_nxt = KIND_HEADER;
      end
      default: begin
        phase_nxt = PH_ERROR;
      end
    endcase
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_VERSION;
      ver_cnt_r <= '0;
      rsn_cnt_r <= '0;
      accum_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (fire) begin
        phase_r   <= phase_nxt;
        ver_cnt_r <= ver_cnt_nxt;
        rsn_cnt_r <= rsn_cnt_nxt;
        accum_r   <= accum_nxt;
        out_vld_r <= 1'b1;
        kind_r    <= kind_nxt;
        byte_r    <= pop_item.byte_val;
        done_r    <= done_nxt;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_vld_r;
  assign out_byte_kind   = kind_r;
  assign out_byte        = byte_r;
  assign out_status_code = accum_r;
  assign out_line_done   = done_r;

endmodule

@@ rtl/core/http_status_line_parser.sv @@
// top level of the http status line parser
//
//  channel  | ports                                        | direction
//  ---------+----------------------------------------------+----------
//  input    | in_valid, in_ready, in_byte                  | in
//  result   | out_valid, out_ready, out_byte_kind,         | out
//           | out_byte, out_status_code, out_line_done     |
//
// one byte per cycle sustained while out_ready stays high; an accepted byte passes the front
// register, the queue and the result register in that order before it shows on the result channel.
// the status multiply-add in the back part is the only multiply per byte.
// synchronous active-low reset returns to the version phase with all counts zero.
// a stalled result channel fills the result register, the two-entry queue and
// the front register before in_ready drops.
module http_status_line_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_byte_kind,
  output logic [7:0]  out_byte,
  output logic [15:0] out_status_code,
  output logic        out_line_done
);
  import hsl_pkg::*;

  logic      push_valid;
  logic      push_ready;
  hsl_item_t push_item;
  logic      pop_valid;
  logic      pop_ready;
  hsl_item_t pop_item;

  // byte classification
  hsl_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  // decoupling queue
  hsl_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  // phase machine and results
  hsl_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .pop_valid       (pop_valid),
    .pop_ready       (pop_ready),
    .pop_item        (pop_item),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte_kind   (out_byte_kind),
    .out_byte        (out_byte),
    .out_status_code (out_status_code),
    .out_line_done   (out_line_done)
  );

endmodule

@@ rtl/core/hsl_checker.sv @@
// port-level checks for the http status line parser, bound to the top level
module hsl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_byte_kind,
  input logic [7:0]  out_byte,
  input logic [15:0] out_status_code,
  input logic        out_line_done
);
  import hsl_pkg::*;

  logic out_xfer;
  logic err_seen_r;
  logic hdr_seen_r;

  assign out_xfer = out_valid && out_ready;

  // track error and header transactions delivered so far
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_seen_r <= 1'b0;
      hdr_seen_r <= 1'b0;
    end else if (out_xfer) begin
      if (out_byte_kind == KIND_ERROR) begin
        err_seen_r <= 1'b1;
      end
      if (out_byte_kind == KIND_HEADER) begin
        hdr_seen_r <= 1'b1;
      end
    end
  end

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_byte_kind))
    else $error("result changed while stalled");

  // line end is a header transaction carrying cr or lf
  a_done_eol: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_line_done |->
      out_byte_kind == KIND_HEADER && (out_byte == CH_CR || out_byte == CH_LF))
    else $error("line end on a byte that is not cr or lf");

  // error is sticky
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && err_seen_r |-> out_byte_kind == KIND_ERROR && !out_line_done)
    else $error("transaction after an error is not an error");

  // once headers begin, every transaction is a header byte and the line ends only once
  a_hdr_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && hdr_seen_r |-> out_byte_kind == KIND_HEADER && !out_line_done)
    else $error("header phase left or line ended twice");

  // status code is frozen during the header phase
  a_status_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && out_byte_kind == KIND_HEADER ##1 out_valid |-> $stable(out_status_code))
    else $error("status code moved after the line ended");

endmodule

bind http_status_line_parser hsl_checker u_hsl_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_byte_kind   (out_byte_kind),
  .out_byte        (out_byte),
  .out_status_code (out_status_code),
  .out_line_done   (out_line_done)
);

@@ dv/tb.sv @@
// testbench for the http status line parser: directed table, random line, predictor check
`timescale 1ns / 100ps

module tb;
  import hsl_pkg::*;

  // number of input bytes in the whole run
  localparam int unsigned N_BYTES = 1300;

  // parser phases of the predictor
  typedef enum logic [2:0] {
    PH_VERSION,
    PH_STATUS,
    PH_REASON,
    PH_HEADER,
    PH_ERROR
  } parse_phase_t;

  // how the reason phrase of the random line ends
  typedef enum int {
    END_EOL_RANDOM,
    END_EOL_FULL,
    END_REASON_OVERFLOW
  } reason_end_t;

  // one classified byte as the result channel shows it
  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  data;
    logic [15:0] status;
    logic        done;
  } byte_class_t;

  // one row of the directed table
  typedef struct packed {
    logic [7:0]  data;
    logic        typed;
    logic [2:0]  kind;
    logic [15:0] status;
    logic        done;
  } line_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_byte;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_byte_kind;
  logic [7:0]  out_byte;
  logic [15:0] out_status_code;
  logic        out_line_done;

  // predictor state
  parse_phase_t pr_phase;
  logic [3:0]   pr_ver_cnt;
  logic [15:0]  pr_status;
  logic [8:0]   pr_rsn_cnt;

  byte_class_t pending_class_q[$];
  int unsigned n_sent;
  int unsigned n_err;
  int unsigned snd_idle;
  int unsigned rcv_idle;
  line_row_t   line_tab[22];

  http_status_line_parser i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_byte         (in_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte_kind   (out_byte_kind),
    .out_byte        (out_byte),
    .out_status_code (out_status_code),
    .out_line_done   (out_line_done)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // classify one byte and advance the predictor state
  function automatic byte_class_t classify_byte(input logic [7:0] b);
    byte_class_t r;
    logic        blank;
    logic        eol;
    int unsigned acc;
    blank = (b == CH_SPACE) || (b == CH_TAB);
    eol = (b == CH_CR) || (b == CH_LF);
    r.kind = KIND_ERROR;
    r.done = 1'b0;
    case (pr_phase)
      PH_VERSION: begin
        if (blank) begin
          if (pr_ver_cnt == 0) begin
            r.kind = KIND_SKIP;
          end else if (pr_ver_cnt != VERSION_LEN) begin
            pr_phase = PH_ERROR;
          end else begin
            pr_status = '0;
            pr_phase = PH_STATUS;
            r.kind = KIND_SKIP;
          end
        end else if (eol || pr_ver_cnt >= VERSION_LEN) begin
          pr_phase = PH_ERROR;
        end else begin
          pr_ver_cnt = pr_ver_cnt + 4'd1;
          r.kind = KIND_VERSION;
        end
      end
      PH_STATUS: begin
        if (blank) begin
          // blanks before any nonzero value keep the status open
          if (pr_status != 0) pr_phase = PH_REASON;
          r.kind = KIND_SKIP;
        end else if (eol) begin
          pr_phase = PH_HEADER;
          r.kind = KIND_HEADER;
          r.done = 1'b1;
        end else if (b >= CH_ZERO && b <= CH_NINE) begin
          acc = pr_status * 10 + (b - CH_ZERO);
          pr_status = (acc > STATUS_MAX) ? STATUS_MAX : acc[15:0];
          r.kind = KIND_SKIP;
        end else begin
          pr_phase = PH_ERROR;
        end
      end
      PH_REASON: begin
        if (eol) begin
          pr_phase = PH_HEADER;
          r.kind = KIND_HEADER;
          r.done = 1'b1;
        end else if (blank && pr_rsn_cnt == 0) begin
          r.kind = KIND_SKIP;
        end else if (pr_rsn_cnt >= REASON_MAX) begin
          pr_phase = PH_ERROR;
        end else begin
          pr_rsn_cnt = pr_rsn_cnt + 9'd1;
          r.kind = KIND_REASON;
        end
      end
      PH_HEADER: r.kind = KIND_HEADER;
      default: pr_phase = PH_ERROR;
    endcase
    r.data = b;
    r.status = pr_status;
    return r;
  endfunction

  // one line per mismatch, printing capped
  task automatic report_mismatch(input string what, input int got, input int want);
    if (n_err < 30) $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    n_err++;
  endtask

  // idle profile follows progress through the run
  task automatic set_idle_profile();
    if (n_sent < N_BYTES / 3) begin
      snd_idle = 22;
      rcv_idle = 55;
    end else if (n_sent < 2 * N_BYTES / 3) begin
      snd_idle = 55;
      rcv_idle = 22;
    end else begin
      snd_idle = 0;
      rcv_idle = 0;
    end
  endtask

  // drive one byte transaction; entered and left at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic typed, input byte_class_t want);
    byte_class_t pred;
    set_idle_profile();
    if ($urandom_range(0, 99) < snd_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(0, 99) < snd_idle) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = classify_byte(b);
    pending_class_q.push_back(typed ? want : pred);
    n_sent++;
    @(negedge clk);
  endtask

  // reason text of any byte value, blanks now and then, never CR or LF
  function automatic logic [7:0] rand_text_byte();
    logic [7:0] b;
    if ($urandom_range(0, 7) == 0) return ($urandom_range(0, 1) != 0) ? CH_SPACE : CH_TAB;
    b = 8'($urandom_range(0, 255));
    while (b == CH_CR || b == CH_LF) b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  // receiver back-pressure
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= rcv_idle);
  end

  // result checker
  always @(posedge clk) begin
    byte_class_t exp_c;
    if (rst_n && out_valid && out_ready) begin
      if (pending_class_q.size() == 0) begin
        report_mismatch("unexpected transaction, byte", int'(out_byte), -1);
      end else begin
        exp_c = pending_class_q.pop_front();
        if (out_byte_kind !== exp_c.kind)
          report_mismatch("byte_kind", int'(out_byte_kind), int'(exp_c.kind));
        if (out_byte !== exp_c.data)
          report_mismatch("out_byte", int'(out_byte), int'(exp_c.data));
        if (out_status_code !== exp_c.status)
          report_mismatch("status_code", int'(out_status_code), int'(exp_c.status));
        if (out_line_done !== exp_c.done)
          report_mismatch("line_done", int'(out_line_done), int'(exp_c.done));
      end
    end
  end

  // stimulus and end of run
  initial begin
    reason_end_t end_mode;
    int unsigned rsn_target;
    byte_class_t want;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_byte = '0;
    n_sent = 0;
    n_err = 0;
    snd_idle = 22;
    rcv_idle = 55;
    pr_phase = PH_VERSION;
    pr_ver_cnt = '0;
    pr_status = '0;
    pr_rsn_cnt = '0;

    // leading blanks, a version with extreme bytes, a saturating status, reason blanks
    line_tab = '{
      '{CH_SPACE, 1'b1, KIND_SKIP,    16'd0,     1'b0},
      '{CH_TAB,   1'b1, KIND_SKIP,    16'd0,     1'b0},
      '{8'h48,    1'b1, KIND_VERSION, 16'd0,     1'b0},
      '{8'h00,    1'b1, KIND_VERSION, 16'd0,     1'b0},
      '{8'h54,    1'b0, KIND_VERSION, 16'd0,     1'b0},
      '{8'h50,    1'b0, KIND_VERSION, 16'd0,     1'b0},
      '{8'h2f,    1'b0, KIND_VERSION, 16'd0,     1'b0},
      '{8'hff,    1'b1, KIND_VERSION, 16'd0,     1'b0},
      '{8'h2e,    1'b0, KIND_VERSION, 16'd0,     1'b0},
      '{8'h31,    1'b1, KIND_VERSION, 16'd0,     1'b0},
      '{CH_SPACE, 1'b1, KIND_SKIP,    16'd0,     1'b0},
      '{CH_TAB,   1'b1, KIND_SKIP,    16'd0,     1'b0},
      '{CH_ZERO,  1'b1, KIND_SKIP,    16'd0,     1'b0},
      '{CH_NINE,  1'b1, KIND_SKIP,    16'd9,     1'b0},
      '{CH_NINE,  1'b1, KIND_SKIP,    16'd99,    1'b0},
      '{CH_NINE,  1'b1, KIND_SKIP,    16'd999,   1'b0},
      '{CH_NINE,  1'b1, KIND_SKIP,    16'd9999,  1'b0},
      '{CH_NINE,  1'b1, KIND_SKIP,    STATUS_MAX, 1'b0},
      '{CH_NINE,  1'b1, KIND_SKIP,    STATUS_MAX, 1'b0},
      '{CH_SPACE, 1'b1, KIND_SKIP,    STATUS_MAX, 1'b0},
      '{CH_TAB,   1'b1, KIND_SKIP,    STATUS_MAX, 1'b0},
      '{CH_SPACE, 1'b1, KIND_SKIP,    STATUS_MAX, 1'b0}
    };

    // hold reset, then release it at a falling edge
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part
    foreach (line_tab[i]) begin
      want.kind = line_tab[i].kind;
      want.data = line_tab[i].data;
      want.status = line_tab[i].status;
      want.done = line_tab[i].done;
      send_byte(line_tab[i].data, line_tab[i].typed, want);
    end

    // random reason phrase and the way it ends
    want = '0;
    end_mode = reason_end_t'($urandom_range(0, 2));
    case (end_mode)
      END_EOL_RANDOM, END_EOL_FULL: begin
        rsn_target = (end_mode == END_EOL_FULL) ? REASON_MAX : $urandom_range(0, REASON_MAX);
        while (pr_rsn_cnt < rsn_target) send_byte(rand_text_byte(), 1'b0, want);
        send_byte(($urandom_range(0, 1) != 0) ? CH_CR : CH_LF, 1'b0, want);
      end
      default: begin
        while (pr_phase != PH_ERROR) send_byte(rand_text_byte(), 1'b0, want);
      end
    endcase

    // after the line: header bytes or sticky error for any byte value
    while (n_sent < N_BYTES) send_byte(8'($urandom_range(0, 255)), 1'b0, want);
    in_valid <= 1'b0;

    // drain
    while (pending_class_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (n_err == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // run limit
  initial begin
    #5000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/hsl_pkg.sv
rtl/core/hsl_front.sv
rtl/core/hsl_queue.sv
rtl/core/hsl_back.sv
rtl/core/http_status_line_parser.sv
rtl/core/hsl_checker.sv
dv/tb.sv
